// File: hdl/tccw_pkg.sv
`timescale 1ns / 1ps
// tccw_pkg: shared types and constants for the text console character writer
// no dependencies; imported by text_console_char_writer_unit

package tccw_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS    = 80;
  localparam int DEF_ROWS       = 25;
  localparam int DEF_TAB_SPACES = 5;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h0F;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7F;

  // control bytes honored by put character
  localparam logic [7:0] CHAR_BS = 8'h08;
  localparam logic [7:0] CHAR_HT = 8'h09;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_MOVE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_PUT,
    ST_BS_WRITE,
    ST_RDATA,
    ST_SCROLL_COPY,
    ST_SCROLL_LAST,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

// File: hdl/text_console_char_writer_unit.sv
`timescale 1ns / 1ps
// text_console_char_writer_unit: screen store, cursor and command sequencer
// depends on tccw_pkg
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  in       | in_valid / in_ready   | opcode, char_code, column, row
//  out      | out_valid / out_ready | cursor_index, cell_char, cell_attr
//  cfg      | cfg_valid / cfg_ready | text_attribute
//
// every item runs from dispatch to done; a printable byte or a tab writes its cells in put,
// a read cell passes the read data state and backspace blanks the cell it moves onto
// a scroll copies each row one row up (copy sweep), then blanks the bottom row,
// clear blanks one cell per cycle through the write port
// after reset a clearing pass over every cell runs before in_ready rises
// the next item is taken while a result still waits; a stalled output only
// holds the sequencer in ST_DONE

module text_console_char_writer_unit
  import tccw_pkg::*;
#(
  parameter int COLUMNS    = DEF_COLUMNS,
  parameter int ROWS       = DEF_ROWS,
  parameter int TAB_SPACES = DEF_TAB_SPACES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_code,
  input  logic [6:0]  column,
  input  logic [4:0]  row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] cursor_index,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  text_attribute
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int PL_W       = $clog2(TAB_SPACES + 1);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELL_COUNT - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] FILL_LAST = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

  state_t state, state_next;

  logic [15:0] mem [CELL_COUNT];
  logic [15:0] rdata;
  logic        we;
  logic [ADDR_W-1:0] wa, ra;
  logic [15:0] wd;

  logic [7:0]        attr;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ADDR_W-1:0] sweep;
  logic [ADDR_W-1:0] copy_addr;
  logic              copy_pending;
  logic [PL_W-1:0]   put_left;
  logic [7:0]        put_char;
  logic [15:0]       cell_hold;

  opcode_t     op_reg;
  logic [7:0]  char_reg;
  logic [6:0]  col_reg;
  logic [4:0]  row_reg;

  logic [COL_W-1:0]  sat_col;
  logic [ROW_W-1:0]  sat_row;
  logic [ADDR_W-1:0] sat_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic [15:0]       cur_addr16;
  logic              col_last, row_last, printable, out_free;

  assign sat_col = (col_reg >= 7'(COLUMNS)) ? COL_W'(COLUMNS - 1) : col_reg[COL_W-1:0];
  assign sat_row = (row_reg >= 5'(ROWS)) ? ROW_W'(ROWS - 1) : row_reg[ROW_W-1:0];
  assign sat_addr = ADDR_W'(sat_col) + ADDR_W'(sat_row) * ROW_STEP;
  assign cur_addr = ADDR_W'(cur_col) + ADDR_W'(cur_row) * ROW_STEP;
  assign cur_addr16 = 16'(cur_addr);
  assign col_last  = (cur_col == COL_W'(COLUMNS - 1));
  assign row_last  = (cur_row == ROW_W'(ROWS - 1));
  assign printable = (char_reg >= PRINT_LO) && (char_reg < PRINT_HI);
  assign out_free  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sweep == FILL_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (op_reg)
          OP_MOVE:  state_next = ST_DONE;
          OP_CLEAR: state_next = ST_FILL;
          OP_READ:  state_next = ST_RDATA;
          default: begin
            if (char_reg == CHAR_LF) begin
              state_next = row_last ? ST_SCROLL_COPY : ST_DONE;
            end else if (char_reg == CHAR_HT || printable) begin
              state_next = ST_PUT;
            end else if (char_reg == CHAR_BS) begin
              state_next = ST_BS_WRITE;
            end else begin
              state_next = ST_DONE;
            end
          end
        endcase
      end
      ST_PUT: begin
        if (col_last && row_last) state_next = ST_SCROLL_COPY;
        else if (put_left > PL_W'(1)) state_next = ST_PUT;
        else state_next = ST_DONE;
      end
      ST_BS_WRITE: state_next = ST_DONE;
      ST_RDATA:    state_next = ST_DONE;
      ST_SCROLL_COPY: begin
        if (sweep == COPY_LAST) state_next = ST_SCROLL_LAST;
      end
      ST_SCROLL_LAST: state_next = ST_FILL;
      ST_FILL: begin
        if (sweep == FILL_LAST) begin
          if (op_reg != OP_CLEAR && put_left != '0) state_next = ST_PUT;
          else state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  // memory port controls and handshake
  always_comb begin
    in_ready = (state == ST_IDLE);
    we = 1'b0;
    wa = sweep;
    wd = {attr, BLANK_CHAR};
    ra = (state == ST_SCROLL_COPY) ? sweep + ROW_STEP : sat_addr;
    if (copy_pending) begin
      // delayed half of the scroll copy, one row up from the read
      we = 1'b1;
      wa = copy_addr;
      wd = rdata;
    end else begin
      case (state)
        ST_INIT: begin
          we = 1'b1;
          wd = {RESET_ATTR, BLANK_CHAR};
        end
        ST_FILL: we = 1'b1;
        ST_PUT: begin
          we = 1'b1;
          wa = cur_addr;
          wd = {attr, put_char};
        end
        ST_BS_WRITE: begin
          we = 1'b1;
          wa = cur_addr;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      sweep        <= '0;
      copy_pending <= 1'b0;
      cur_col      <= '0;
      cur_row      <= '0;
      attr         <= RESET_ATTR;
      out_valid    <= 1'b0;
      put_left     <= '0;
      op_reg       <= OP_PUT;
    end else begin
      state        <= state_next;
      copy_pending <= (state == ST_SCROLL_COPY);
      copy_addr    <= sweep;
      if (cfg_valid) attr <= text_attribute;
      // ST_DONE reloads the result register itself
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;

      case (state)
        ST_INIT: sweep <= sweep + ADDR_W'(1);
        ST_IDLE: begin
          if (in_valid) begin
            op_reg   <= opcode_t'(opcode);
            char_reg <= char_code;
            col_reg  <= column;
            row_reg  <= row;
          end
        end
        ST_DISPATCH: begin
          sweep <= '0;
          case (op_reg)
            OP_MOVE: begin
              cur_col <= sat_col;
              cur_row <= sat_row;
            end
            OP_PUT: begin
              if (char_reg == CHAR_LF) begin
                cur_col  <= '0;
                put_left <= '0;
                if (!row_last) cur_row <= cur_row + ROW_W'(1);
              end else if (char_reg == CHAR_CR) begin
                cur_col <= '0;
              end else if (char_reg == CHAR_HT) begin
                put_left <= PL_W'(TAB_SPACES);
                put_char <= BLANK_CHAR;
              end else if (char_reg == CHAR_BS) begin
                if (cur_col != '0) begin
                  cur_col <= cur_col - COL_W'(1);
                end else if (cur_row != '0) begin
                  cur_row <= cur_row - ROW_W'(1);
                  cur_col <= COL_W'(COLUMNS - 1);
                end
              end else if (printable) begin
                put_left <= PL_W'(1);
                put_char <= char_reg;
              end
            end
            default: ;
          endcase
        end
        ST_PUT: begin
          put_left <= put_left - PL_W'(1);
          sweep    <= '0;
          if (col_last) begin
            cur_col <= '0;
            if (!row_last) cur_row <= cur_row + ROW_W'(1);
          end else begin
            cur_col <= cur_col + COL_W'(1);
          end
        end
        ST_RDATA: cell_hold <= rdata;
        ST_SCROLL_COPY: sweep <= sweep + ADDR_W'(1);
        ST_SCROLL_LAST: sweep <= COPY_LAST + ADDR_W'(1);
        ST_FILL: sweep <= sweep + ADDR_W'(1);
        ST_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            cursor_index <= cur_addr16[10:0];
            cell_char    <= (op_reg == OP_READ) ? cell_hold[7:0] : 8'h00;
            cell_attr    <= (op_reg == OP_READ) ? cell_hold[15:8] : 8'h00;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_col < COL_W'(COLUMNS)) && (cur_row < ROW_W'(ROWS)))
    else $error("cursor left the screen");

  a_copy_window: assert property (@(posedge clk) disable iff (rst)
    copy_pending |-> (state == ST_SCROLL_COPY || state == ST_SCROLL_LAST))
    else $error("scroll copy write outside the scroll sweep");

  a_put_count: assert property (@(posedge clk) disable iff (rst)
    put_left <= PL_W'(TAB_SPACES))
    else $error("put count above tab width");

  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL || state == ST_INIT || state == ST_SCROLL_COPY)
      |-> sweep <= FILL_LAST)
    else $error("sweep address beyond the screen");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> out_valid)
    else $error("result not presented after finishing an item");
`endif

endmodule
